@@ hw/rtl/hcbp_pkg.sv @@
package hcbp_pkg;

  localparam int BYTE_BITS = 8;
  localparam int PEND_W    = 7;
  localparam int PCNT_W    = 3;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] valid_bits;
    logic       error;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

@@ hw/rtl/hcbp_res_fifo.sv @@
module hcbp_res_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hcbp_pkg::push_t                   push,
  input  logic                              pop,
  output hcbp_pkg::res_t                    head,
  output logic [hcbp_pkg::FIFO_CNT_W-1:0]   count
);

  hcbp_pkg::res_t                     fifo_r [hcbp_pkg::FIFO_DEPTH];
  logic [hcbp_pkg::FIFO_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [hcbp_pkg::FIFO_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [hcbp_pkg::FIFO_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [hcbp_pkg::FIFO_PTR_W-1:0]    wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + hcbp_pkg::FIFO_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + hcbp_pkg::FIFO_PTR_W'(push.num);
    rd_ptr_nxt = rd_ptr_r + hcbp_pkg::FIFO_PTR_W'(pop);
    cnt_nxt    = cnt_r + hcbp_pkg::FIFO_CNT_W'(push.num) - hcbp_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      fifo_r[wr_ptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      fifo_r[wr_ptr_p1] <= push.second;
    end
  end

  assign head  = fifo_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

@@ hw/rtl/huffman_code_bit_packer_core.sv @@
// channel  | dir | tdata (low bit up)                        | tuser | tlast
// in_      | in  | symbol 8, code_word 16, code_len 5, pad 3 | op 2  | -
// out_     | out | out_byte 8, valid_bits 4, pad 4           | error | last
//
// an item is looked up in the code memory in its accept cycle and packed the
// next cycle; its results enter an 8-entry result queue
// the result port drains one byte per cycle while out_tready is high; an encode
// item yields 0 to 2 bytes, so sustained rate is set by that port
// reset clears the per-symbol valid bits and pending buffer
// in_tready drops when the queue cannot take the worst case of items in flight
module huffman_code_bit_packer_core #(
  parameter int MAX_CODE_BITS = 16,
  parameter int SYMBOLS       = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // symbol, code_word, code_len
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_byte, valid_bits
  output logic        out_tuser,  // error
  output logic        out_tlast
);

  localparam int CW    = (MAX_CODE_BITS < 16) ? MAX_CODE_BITS : 16;
  localparam int LW    = $clog2(CW + 1);
  localparam int IW    = (SYMBOLS > 2) ? $clog2(SYMBOLS) : 1;
  localparam int ACC_W = hcbp_pkg::PEND_W + CW;
  localparam int TW    = $clog2(ACC_W + 1);

  logic [1:0]  in_op;
  logic [7:0]  in_symbol;
  logic [15:0] in_code_word;
  logic [4:0]  in_code_len;
  logic        in_fire;
  logic        sym_ok;
  logic [IW-1:0] sym_idx;
  logic [4:0]  len_sat;
  logic [CW-1:0] code_m;

  logic [CW+LW-1:0] mem_r [SYMBOLS];
  logic [SYMBOLS-1:0] hit_r;

  logic          s1_vld_r;
  logic [1:0]    s1_op_r;
  logic          s1_sym_ok_r;
  logic [CW-1:0] rd_code_r;
  logic [LW-1:0] rd_len_r;
  logic          rd_hit_r;

  logic [hcbp_pkg::PEND_W-1:0] pend_bits_r, pend_bits_nxt;
  logic [hcbp_pkg::PCNT_W-1:0] pend_cnt_r, pend_cnt_nxt;

  logic [LW-1:0]    clen;
  logic [ACC_W-1:0] acc;
  logic [TW-1:0]    total;
  logic [2:0]       rem;
  logic [7:0]       byte0, byte1, flush_byte;
  logic [hcbp_pkg::PEND_W-1:0] rem_bits;

  hcbp_pkg::push_t push;
  hcbp_pkg::res_t  head;
  logic [hcbp_pkg::FIFO_CNT_W-1:0] q_cnt;
  logic [hcbp_pkg::FIFO_CNT_W+1:0] q_need;
  logic pop;

  assign in_symbol    = in_tdata[7:0];
  assign in_code_word = in_tdata[23:8];
  assign in_code_len  = in_tdata[28:24];
  assign in_op        = in_tuser;

  assign in_fire = in_tvalid && in_tready;
  assign sym_ok  = ({1'b0, in_symbol} < 9'(SYMBOLS));
  assign sym_idx = in_symbol[IW-1:0];
  assign len_sat = (in_code_len > 5'(CW)) ? 5'(CW) : in_code_len;

  always_comb begin
    for (int i = 0; i < CW; i++) begin
      code_m[i] = in_code_word[i] && (5'(i) < len_sat);
    end
  end

  // code memory: written and read at accept, so a load is seen by the next item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (sym_ok && in_op == hcbp_pkg::OP_LOAD) begin
        mem_r[sym_idx] <= {code_m, LW'(len_sat)};
      end
      {rd_code_r, rd_len_r} <= mem_r[sym_idx];
      rd_hit_r              <= hit_r[sym_idx];
      s1_op_r               <= in_op;
      s1_sym_ok_r           <= sym_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= '0;
      s1_vld_r    <= 1'b0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      if (in_fire && sym_ok && in_op == hcbp_pkg::OP_LOAD) begin
        hit_r[sym_idx] <= 1'b1;
      end
      s1_vld_r    <= in_fire;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  // packing stage
  assign clen  = rd_hit_r ? rd_len_r : '0;
  assign acc   = (ACC_W'(pend_bits_r) << clen) | ACC_W'(rd_code_r);
  assign total = TW'(pend_cnt_r) + TW'(clen);
  assign rem   = total[2:0];
  assign byte0 = 8'(acc >> (32'(total) - 32'(hcbp_pkg::BYTE_BITS)));
  assign byte1 = 8'(acc >> (32'(total) - 32'(2 * hcbp_pkg::BYTE_BITS)));
  assign flush_byte = 8'({1'b0, pend_bits_r} << (4'(hcbp_pkg::BYTE_BITS) - {1'b0, pend_cnt_r}));

  always_comb begin
    for (int i = 0; i < hcbp_pkg::PEND_W; i++) begin
      rem_bits[i] = acc[i] && (3'(i) < rem);
    end
  end

  always_comb begin
    push          = '0;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (s1_vld_r) begin
      unique case (s1_op_r)
        hcbp_pkg::OP_ENCODE: begin
          if (!s1_sym_ok_r || clen == '0) begin
            push.num         = 2'd1;
            push.first.error = 1'b1;
            push.first.last  = 1'b1;
          end else begin
            pend_bits_nxt = rem_bits;
            pend_cnt_nxt  = rem;
            push.first.out_byte    = byte0;
            push.first.valid_bits  = 4'(hcbp_pkg::BYTE_BITS);
            push.second.out_byte   = byte1;
            push.second.valid_bits = 4'(hcbp_pkg::BYTE_BITS);
            push.second.last       = 1'b1;
            if (32'(total) >= 32'(2 * hcbp_pkg::BYTE_BITS)) begin
              push.num = 2'd2;
            end else if (32'(total) >= 32'(hcbp_pkg::BYTE_BITS)) begin
              push.num        = 2'd1;
              push.first.last = 1'b1;
            end
          end
        end
        hcbp_pkg::OP_FLUSH: begin
          if (pend_cnt_r != '0) begin
            push.num              = 2'd1;
            push.first.out_byte   = flush_byte;
            push.first.valid_bits = 4'(pend_cnt_r);
            push.first.last       = 1'b1;
            pend_bits_nxt         = '0;
            pend_cnt_nxt          = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  hcbp_res_fifo u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_cnt)
  );

  // room for the item in the packing stage and the one being accepted
  assign q_need    = (hcbp_pkg::FIFO_CNT_W+2)'(q_cnt)
                   + (s1_vld_r ? (hcbp_pkg::FIFO_CNT_W+2)'(2) : '0)
                   + (hcbp_pkg::FIFO_CNT_W+2)'(2);
  assign in_tready = (q_need <= (hcbp_pkg::FIFO_CNT_W+2)'(hcbp_pkg::FIFO_DEPTH));

  assign out_tvalid = (q_cnt != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {4'b0000, head.valid_bits, head.out_byte};
  assign out_tuser  = head.error;
  assign out_tlast  = head.last;

endmodule

@@ tb/huffman_code_bit_packer_core_tb.sv @@
`timescale 1ns / 1ps

module huffman_code_bit_packer_core_tb;

  localparam int MAX_CODE_BITS = 16;
  localparam int SYMBOLS       = 256;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  class packer_scoreboard;
    localparam int LEN_CAP = (MAX_CODE_BITS < 16) ? MAX_CODE_BITS : 16;

    logic [15:0] code_mem [256];
    logic [4:0]  len_mem  [256];
    logic [6:0]  pend_bits;
    logic [2:0]  pend_cnt;
    hcbp_pkg::res_t expected_bytes [$];
    int          errors;

    function new();
      foreach (len_mem[i]) begin
        len_mem[i]  = '0;
        code_mem[i] = '0;
      end
      pend_bits = '0;
      pend_cnt  = '0;
      errors    = 0;
    endfunction

    // predicts the bytes that one accepted transaction produces
    function void accept_item(logic [1:0] op, logic [7:0] sym, logic [15:0] word,
                              logic [4:0] len);
      int             clen;
      int             total;
      logic [31:0]    acc;
      hcbp_pkg::res_t r;
      if (op == hcbp_pkg::OP_LOAD) begin
        if (int'(sym) < SYMBOLS) begin
          clen = (int'(len) > LEN_CAP) ? LEN_CAP : int'(len);
          code_mem[sym] = 16'(32'(word) & ((32'd1 << clen) - 32'd1));
          len_mem[sym]  = 5'(clen);
        end
      end else if (op == hcbp_pkg::OP_ENCODE) begin
        if (int'(sym) >= SYMBOLS || len_mem[sym] == 5'd0) begin
          r.out_byte   = '0;
          r.valid_bits = '0;
          r.error      = 1'b1;
          r.last       = 1'b1;
          expected_bytes.push_back(r);
        end else begin
          clen  = int'(len_mem[sym]);
          acc   = (32'(pend_bits) << clen) | 32'(code_mem[sym]);
          total = int'(pend_cnt) + clen;
          while (total >= hcbp_pkg::BYTE_BITS) begin
            r.out_byte   = 8'(acc >> (total - hcbp_pkg::BYTE_BITS));
            total        = total - hcbp_pkg::BYTE_BITS;
            r.valid_bits = 4'(hcbp_pkg::BYTE_BITS);
            r.error      = 1'b0;
            r.last       = (total < hcbp_pkg::BYTE_BITS);
            expected_bytes.push_back(r);
          end
          pend_cnt  = 3'(total);
          pend_bits = 7'(acc & ((32'd1 << total) - 32'd1));
        end
      end else if (op == hcbp_pkg::OP_FLUSH) begin
        if (pend_cnt != 3'd0) begin
          r.out_byte   = 8'(32'(pend_bits) << (hcbp_pkg::BYTE_BITS - int'(pend_cnt)));
          r.valid_bits = 4'(pend_cnt);
          r.error      = 1'b0;
          r.last       = 1'b1;
          expected_bytes.push_back(r);
          pend_bits = '0;
          pend_cnt  = '0;
        end
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_byte(hcbp_pkg::res_t got);
      hcbp_pkg::res_t want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %h bits %0d err %b last %b",
                                  got.out_byte, got.valid_bits, got.error, got.last));
      end else begin
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte || got.valid_bits !== want.valid_bits ||
            got.error !== want.error || got.last !== want.last) begin
          report_mismatch($sformatf(
            "got byte %h bits %0d err %b last %b, want byte %h bits %0d err %b last %b",
            got.out_byte, got.valid_bits, got.error, got.last,
            want.out_byte, want.valid_bits, want.error, want.last));
        end
      end
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  packer_scoreboard sb = new();

  bit          steady    = 1'b0;
  bit          long_hold = 1'b0;
  int          cycles    = 0;
  logic [7:0]  coded_syms [$];

  huffman_code_bit_packer_core #(
    .MAX_CODE_BITS(MAX_CODE_BITS),
    .SYMBOLS      (SYMBOLS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
        out_tready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0 && $urandom_range(0, 2) == 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_byte({out_tdata[7:0], out_tdata[11:8], out_tuser, out_tlast});
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic [1:0] op, logic [7:0] sym, logic [15:0] word,
                           logic [4:0] len);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, len, word, sym};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.accept_item(op, sym, word, len);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic load_code(logic [7:0] sym, logic [15:0] word, logic [4:0] len);
    send_item(hcbp_pkg::OP_LOAD, sym, word, len);
    if (len != 5'd0) coded_syms.push_back(sym);
  endtask

  task automatic encode_sym(logic [7:0] sym);
    send_item(hcbp_pkg::OP_ENCODE, sym, 16'($urandom), 5'($urandom));
  endtask

  task automatic flush_bits();
    send_item(hcbp_pkg::OP_FLUSH, 8'($urandom), 16'($urandom), 5'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic random_phase(int n_items);
    int          r;
    logic [7:0]  sym;
    logic [4:0]  len;
    repeat ($urandom_range(4, 24)) begin
      r = $urandom_range(0, 99);
      if (r < 80) len = 5'($urandom_range(1, 16));
      else if (r < 90) len = 5'd0;
      else len = 5'($urandom_range(17, 31));
      load_code(8'($urandom), 16'($urandom), len);
    end
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        if (coded_syms.size() != 0 && $urandom_range(0, 9) != 0)
          sym = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
        else
          sym = 8'($urandom);
        encode_sym(sym);
      end else if (r < 88) begin
        flush_bits();
      end else if (r < 95) begin
        load_code(8'($urandom), 16'($urandom), 5'($urandom_range(0, 16)));
      end else begin
        send_item(OP_UNUSED, 8'($urandom), 16'($urandom), 5'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    encode_sym(8'h00);                  // no code yet
    flush_bits();                       // nothing pending
    load_code(8'h00, 16'h0001, 5'd1);
    load_code(8'hFF, 16'hFFFF, 5'd16);
    load_code(8'h55, 16'hAAAA, 5'd31);  // length saturates
    load_code(8'hAA, 16'hFFF8, 5'd3);   // upper word bits masked
    load_code(8'h01, 16'h005A, 5'd7);
    encode_sym(8'hFF);
    encode_sym(8'h00);
    encode_sym(8'hFF);
    encode_sym(8'h55);
    encode_sym(8'hAA);
    encode_sym(8'h01);
    flush_bits();
    send_item(OP_UNUSED, 8'hFF, 16'hFFFF, 5'd31);
    load_code(8'h00, 16'h5555, 5'd0);   // clears the entry
    encode_sym(8'h01);
    encode_sym(8'h00);                  // error keeps pending bits
    flush_bits();
    load_code(8'h00, 16'h0000, 5'd16);
    encode_sym(8'h00);
    encode_sym(8'h00);
    flush_bits();
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      steady = (phase == 2);
      if (phase == 3) begin
        long_hold = 1'b1;
        steady    = 1'b1;
        repeat (60) encode_sym(8'hFF);
        steady = 1'b0;
      end
      random_phase(230);
      if (phase == 1 || phase == 4) wait_drained();
    end
    steady = 1'b0;

    wait_drained();
    if (sb.expected_bytes.size() != 0)
      sb.report_mismatch($sformatf("%0d bytes never arrived", sb.expected_bytes.size()));
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_res_fifo.sv
hw/rtl/huffman_code_bit_packer_core.sv
tb/huffman_code_bit_packer_core_tb.sv
